// ----- rtl/tec_pkg.sv -----
// ----------------------------------------------------------------------------
// tec_pkg
// shared types, type codes, float constants and helpers for the cast block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tec_pkg;

  localparam int TEC_QUEUE_DEPTH = 2;

  localparam logic [3:0] TY_BOOL = 4'd0;
  localparam logic [3:0] TY_U8   = 4'd1;
  localparam logic [3:0] TY_I8   = 4'd2;
  localparam logic [3:0] TY_I16  = 4'd3;
  localparam logic [3:0] TY_I32  = 4'd4;
  localparam logic [3:0] TY_I64  = 4'd5;
  localparam logic [3:0] TY_F16  = 4'd6;
  localparam logic [3:0] TY_BF16 = 4'd7;
  localparam logic [3:0] TY_F32  = 4'd8;
  localparam logic [3:0] TY_F64  = 4'd9;

  localparam logic [3:0] CFG_SOURCE = 4'd0;
  localparam logic [3:0] CFG_TARGET = 4'd1;

  localparam logic [63:0] DBL_ONE       = 64'h3ff0_0000_0000_0000;
  localparam logic [31:0] SGL_INF       = 32'h7f80_0000;
  localparam logic [31:0] SGL_QNAN      = 32'h7fc0_0000;
  localparam logic [15:0] H_INF         = 16'h7c00;
  localparam logic [15:0] H_QBIT        = 16'h0200;
  localparam logic [24:0] H_RND         = 25'h000_1000;
  localparam logic [9:0]  H_BIAS_ADJ    = 10'd112;
  localparam logic [23:0] SGL_HIDDEN    = 24'h80_0000;
  localparam logic [15:0] HALF_MAN_MASK = 16'h03ff;
  localparam logic [10:0] EXP_INT_TOP   = 11'd1086;

  typedef enum logic [1:0] {
    MODE_PASS   = 2'd0,
    MODE_DIRECT = 2'd1,
    MODE_NORM   = 2'd2
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic        sign;
    logic [10:0] expo;
    logic [63:0] word;
    logic [3:0]  tgt;
  } item_t;

  function automatic logic [63:0] type_mask(input logic [3:0] t);
    logic [63:0] m;
    unique case (t)
      TY_BOOL, TY_U8, TY_I8:   m = 64'h0000_0000_0000_00ff;
      TY_I16, TY_F16, TY_BF16: m = 64'h0000_0000_0000_ffff;
      TY_I32, TY_F32:          m = 64'h0000_0000_ffff_ffff;
      default:                 m = 64'hffff_ffff_ffff_ffff;
    endcase
    return m;
  endfunction

  function automatic logic [63:0] pos_lim(input logic [3:0] t);
    logic [63:0] m;
    unique case (t)
      TY_U8:   m = 64'd256;
      TY_I8:   m = 64'd128;
      TY_I16:  m = 64'd32768;
      TY_I32:  m = 64'h0000_0000_8000_0000;
      default: m = 64'h8000_0000_0000_0000;
    endcase
    return m;
  endfunction

  function automatic logic [63:0] neg_lim(input logic [3:0] t);
    logic [63:0] m;
    unique case (t)
      TY_U8:   m = 64'd0;
      TY_I8:   m = 64'd128;
      TY_I16:  m = 64'd32768;
      TY_I32:  m = 64'h0000_0000_8000_0000;
      default: m = 64'h8000_0000_0000_0000;
    endcase
    return m;
  endfunction

  function automatic logic [63:0] sat_max(input logic [3:0] t);
    logic [63:0] m;
    unique case (t)
      TY_U8:   m = 64'hff;
      TY_I8:   m = 64'h7f;
      TY_I16:  m = 64'h7fff;
      TY_I32:  m = 64'h7fff_ffff;
      TY_I64:  m = 64'h7fff_ffff_ffff_ffff;
      default: m = 64'd0;
    endcase
    return m;
  endfunction

  function automatic logic [63:0] sat_min(input logic [3:0] t);
    logic [63:0] m;
    unique case (t)
      TY_I8:   m = 64'h80;
      TY_I16:  m = 64'h8000;
      TY_I32:  m = 64'h8000_0000;
      TY_I64:  m = 64'h8000_0000_0000_0000;
      default: m = 64'd0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tensor_element_type_cast.sv -----
// ----------------------------------------------------------------------------
// tensor_element_type_cast
// casts raw tensor elements between bool, integer and floating-point types
// ----------------------------------------------------------------------------
// Items enter through push/full and leave through empty/pop. Each element is
// classified on entry and queued; the back end widens it to binary64 and
// narrows it to the target type. Equal source and target types go to the
// output register straight from idle; other items pass the narrow and pack
// states, after the normalising loop and rounding for integer and finite
// float sources that need them; the loop shifts eight bits or one bit per
// cycle. That loop and the single output register set the rate. Config writes
// (index 0 source type, 1 target type) must only happen while idle.
`timescale 1ns / 1ps
`default_nettype none

module tensor_element_type_cast #(
  parameter int QUEUE_DEPTH = tec_pkg::TEC_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [63:0] raw_element,
  output logic             empty,
  input  wire logic        pop,
  output logic [63:0]      cast_element,
  output logic             range_flag,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [3:0]  cfg_data
);
  import tec_pkg::*;

  logic [3:0] source_type;
  logic [3:0] target_type;
  item_t      f_item;
  item_t      q_item;
  logic       q_empty;
  logic       q_pop;
  logic       out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_type <= TY_F32;
      target_type <= TY_F32;
    end else if (cfg_we) begin
      if (4'(cfg_index) == CFG_SOURCE) begin
        source_type <= cfg_data;
      end else if (4'(cfg_index) == CFG_TARGET) begin
        target_type <= cfg_data;
      end
    end
  end

  tec_front u_front (
    .raw  (raw_element),
    .src  (source_type),
    .tgt  (target_type),
    .item (f_item)
  );

  tec_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (f_item),
    .full  (full),
    .pop   (q_pop),
    .dout  (q_item),
    .empty (q_empty)
  );

  tec_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_item    (q_item),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_pop   (pop),
    .out_data  (cast_element),
    .out_flag  (range_flag)
  );

  assign empty = !out_valid;

endmodule

`default_nettype wire

// ----- rtl/tec_front.sv -----
// ----------------------------------------------------------------------------
// tec_front
// classifies an incoming element and prepares it for the binary64 datapath
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tec_front (
  input  wire logic [63:0]   raw,
  input  wire logic [3:0]    src,
  input  wire logic [3:0]    tgt,
  output tec_pkg::item_t     item
);
  import tec_pkg::*;

  logic [4:0]  hex;
  logic [9:0]  hman;
  logic [31:0] w32;
  logic [7:0]  se;
  logic [22:0] sf;
  logic [63:0] ival;
  logic [63:0] mag;

  always_comb begin
    hex  = raw[14:10];
    hman = 10'(raw[15:0] & HALF_MAN_MASK);
    w32  = (src == TY_BF16) ? {raw[15:0], 16'b0} : raw[31:0];
    se   = w32[30:23];
    sf   = w32[22:0];
    unique case (src)
      TY_I8:   ival = {{56{raw[7]}}, raw[7:0]};
      TY_I16:  ival = {{48{raw[15]}}, raw[15:0]};
      TY_I32:  ival = {{32{raw[31]}}, raw[31:0]};
      TY_I64:  ival = raw;
      default: ival = {56'b0, raw[7:0]};
    endcase
    mag = ival[63] ? (64'd0 - ival) : ival;

    item.mode = MODE_DIRECT;
    item.sign = 1'b0;
    item.expo = EXP_INT_TOP;
    item.word = '0;
    item.tgt  = tgt;

    if (src == tgt && src <= TY_F64) begin
      item.mode = MODE_PASS;
      item.word = raw & type_mask(src);
    end else begin
      unique case (src)
        TY_BOOL: begin
          item.word = (raw[7:0] != 8'd0) ? DBL_ONE : 64'd0;
        end
        TY_U8, TY_I8, TY_I16, TY_I32, TY_I64: begin
          if (mag != 64'd0) begin
            item.mode = MODE_NORM;
            item.sign = ival[63];
            item.word = mag;
          end
        end
        TY_F16: begin
          if (hex == 5'h1f) begin
            item.word = (hman != 10'd0) ?
              ({raw[15], 11'h7ff, 1'b1, 51'b0} | {12'b0, hman, 42'b0}) :
              {raw[15], 11'h7ff, 52'b0};
          end else if (hex == 5'd0 && hman == 10'd0) begin
            item.word = {raw[15], 63'b0};
          end else begin
            item.mode = MODE_NORM;
            item.sign = raw[15];
            item.word = (hex == 5'd0) ? 64'(hman) : 64'({1'b1, hman});
            item.expo = (hex == 5'd0) ? 11'd1062 : 11'd1061 + 11'(hex);
          end
        end
        TY_BF16, TY_F32: begin
          if (se == 8'hff) begin
            item.word = (sf != 23'd0) ?
              ({w32[31], 11'h7ff, 1'b1, 51'b0} | {12'b0, sf, 29'b0}) :
              {w32[31], 11'h7ff, 52'b0};
          end else if (se == 8'd0 && sf == 23'd0) begin
            item.word = {w32[31], 63'b0};
          end else begin
            item.mode = MODE_NORM;
            item.sign = w32[31];
            item.word = (se == 8'd0) ? 64'(sf) : 64'(SGL_HIDDEN | 24'(sf));
            item.expo = (se == 8'd0) ? 11'd937 : 11'd936 + 11'(se);
          end
        end
        TY_F64: begin
          item.word = raw;
        end
        default: begin
          item.word = '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tec_fifo.sv -----
// ----------------------------------------------------------------------------
// tec_fifo
// short queue of classified items between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tec_fifo #(
  parameter int DEPTH = tec_pkg::TEC_QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire tec_pkg::item_t din,
  output logic                full,
  input  wire logic           pop,
  output tec_pkg::item_t      dout,
  output logic                empty
);
  import tec_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tec_back.sv -----
// ----------------------------------------------------------------------------
// tec_back
// normalises to binary64, narrows and packs the target element
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tec_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire tec_pkg::item_t q_item,
  input  wire logic           q_empty,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_pop,
  output logic [63:0]         out_data,
  output logic                out_flag
);
  import tec_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_NORM   = 5'b00010,
    ST_ROUND  = 5'b00100,
    ST_NARROW = 5'b01000,
    ST_PACK   = 5'b10000
  } state_t;

  state_t      state;
  state_t      state_next;
  logic        sign;
  logic [10:0] expo;
  logic [63:0] mag;
  logic [63:0] db;
  logic [31:0] nw;
  logic [3:0]  tgt;
  logic        slot_free;
  logic        out_write;
  logic [63:0] res;
  logic        flag;
  logic [62:0] rnd_sum;
  logic        rnd_up;

  function automatic logic [31:0] narrow_double(input logic [63:0] b);
    logic               s;
    logic [10:0]        e;
    logic [51:0]        f;
    logic signed [12:0] fe;
    logic [54:0]        m;
    logic [6:0]         sh;
    logic [54:0]        q;
    logic [54:0]        rem;
    logic [54:0]        half;
    logic [7:0]         fe8;
    logic [31:0]        r;
    s  = b[63];
    e  = b[62:52];
    f  = b[51:0];
    fe = $signed({2'b0, e}) - 13'sd896;
    m  = {2'b0, 1'b1, f};
    r  = {s, 31'b0};
    sh = 7'd29;
    q  = '0;
    rem  = '0;
    half = '0;
    fe8  = '0;
    if (e == 11'h7ff) begin
      r = (f != 52'd0) ? ({s, 31'b0} | SGL_QNAN | {9'b0, f[51:29]}) : ({s, 31'b0} | SGL_INF);
    end else if (e == 11'd0) begin
      r = {s, 31'b0};
    end else if (fe >= 13'sd255) begin
      r = {s, 31'b0} | SGL_INF;
    end else if (fe <= -13'sd25) begin
      r = {s, 31'b0};
    end else begin
      sh   = (fe >= 13'sd1) ? 7'd29 : 7'(13'sd30 - fe);
      q    = m >> sh;
      rem  = m & ((55'd1 << sh) - 55'd1);
      half = 55'd1 << (sh - 7'd1);
      if (rem > half || (rem == half && q[0])) begin
        q = q + 55'd1;
      end
      if (fe >= 13'sd1) begin
        fe8 = fe[7:0] - 8'd1;
        r   = {s, 31'b0} | ((32'(fe8) << 23) + q[31:0]);
      end else begin
        r = {s, 31'b0} | q[31:0];
      end
    end
    return r;
  endfunction

  function automatic logic [15:0] single_to_half(input logic [31:0] b);
    logic [15:0]        sg;
    logic [7:0]         e8;
    logic [22:0]        man;
    logic signed [9:0]  ex;
    logic [3:0]         sh;
    logic [23:0]        t24;
    logic [15:0]        h;
    sg  = {b[31], 15'b0};
    e8  = b[30:23];
    man = b[22:0];
    ex  = $signed({2'b0, e8}) - $signed(H_BIAS_ADJ);
    sh  = '0;
    t24 = '0;
    if (e8 == 8'hff && man != 23'd0) begin
      h = sg | H_INF | H_QBIT;
    end else if (ex <= 10'sd0) begin
      if (ex < -10'sd10) begin
        h = sg;
      end else begin
        sh  = 4'(10'sd1 - ex);
        t24 = (SGL_HIDDEN | man) >> sh;
        h   = sg | 16'((25'(t24) + H_RND) >> 13);
      end
    end else if (ex >= 10'sd31) begin
      h = sg | H_INF;
    end else begin
      h = sg + 16'({ex[4:0], 10'b0}) + 16'((25'(man) + H_RND) >> 13);
    end
    return h;
  endfunction

  function automatic logic [64:0] to_int(input logic [63:0] d, input logic [3:0] t);
    logic [10:0] e;
    logic [51:0] f;
    logic [63:0] sig;
    logic [5:0]  u;
    logic [63:0] imag;
    logic        big;
    logic        nan;
    logic        in_rng;
    logic [63:0] r;
    logic        fl;
    e    = d[62:52];
    f    = d[51:0];
    sig  = 64'({1'b1, f});
    nan  = (e == 11'h7ff) && (f != 52'd0);
    imag = '0;
    big  = 1'b0;
    u    = '0;
    if (e < 11'd1023) begin
      imag = '0;
    end else if (e > 11'd1086) begin
      big = 1'b1;
    end else begin
      u = 6'(e - 11'd1023);
      if (u <= 6'd52) begin
        imag = sig >> (6'd52 - u);
      end else begin
        imag = sig << (u - 6'd52);
      end
    end
    in_rng = !big && (d[63] ? (imag <= neg_lim(t)) : (imag < pos_lim(t)));
    if (nan) begin
      r  = '0;
      fl = 1'b1;
    end else if (in_rng) begin
      r  = (d[63] ? (64'd0 - imag) : imag) & type_mask(t);
      fl = 1'b0;
    end else begin
      r  = d[63] ? sat_min(t) : sat_max(t);
      fl = 1'b1;
    end
    return {fl, r};
  endfunction

  assign slot_free = !out_valid || out_pop;
  assign q_pop     = (state == ST_IDLE) && !q_empty && slot_free;
  assign rnd_up    = mag[10] && ((|mag[9:0]) || mag[11]);
  assign rnd_sum   = {expo, mag[62:11]} + 63'(rnd_up);

  always_comb begin
    res = '0;
    flag = 1'b0;
    unique case (tgt)
      TY_BOOL: res = {63'b0, db[62:0] != 63'd0};
      TY_U8, TY_I8, TY_I16, TY_I32, TY_I64: {flag, res} = to_int(db, tgt);
      TY_F16:  res = {48'b0, single_to_half(nw)};
      TY_BF16: res = {48'b0, nw[31:16]};
      TY_F32:  res = {32'b0, nw};
      TY_F64:  res = db;
      default: res = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    out_write  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_pop) begin
          unique case (q_item.mode)
            MODE_PASS:   out_write  = 1'b1;
            MODE_NORM:   state_next = ST_NORM;
            default:     state_next = ST_NARROW;
          endcase
        end
      end
      ST_NORM:   if (mag[63]) state_next = ST_ROUND;
      ST_ROUND:  state_next = ST_NARROW;
      ST_NARROW: state_next = ST_PACK;
      ST_PACK: begin
        out_write  = 1'b1;
        state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_write) begin
        out_valid <= 1'b1;
      end else if (out_pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (q_pop) begin
          sign <= q_item.sign;
          expo <= q_item.expo;
          mag  <= q_item.word;
          db   <= q_item.word;
          tgt  <= q_item.tgt;
          if (q_item.mode == MODE_PASS) begin
            out_data <= q_item.word;
            out_flag <= 1'b0;
          end
        end
      end
      ST_NORM: begin
        if (!mag[63]) begin
          if (mag[63:56] == 8'd0) begin
            mag  <= mag << 8;
            expo <= expo - 11'd8;
          end else begin
            mag  <= mag << 1;
            expo <= expo - 11'd1;
          end
        end
      end
      ST_ROUND:  db <= {sign, rnd_sum};
      ST_NARROW: nw <= narrow_double(db);
      ST_PACK: begin
        out_data <= res & type_mask(tgt);
        out_flag <= flag;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
